// ----- design/sors_pkg.sv -----
// Shared types and constants for the scatter-order radiance store.
// Used by the channel interfaces, the controller and the datapath.
package sors_pkg;

    localparam int IDX_W = 14;
    localparam int VAL_W = 64;
    localparam int THR_W = 20;
    localparam logic [THR_W-1:0] THR_RESET = 20'd110;
    localparam int MUL_STEPS = 4;

    typedef enum logic [2:0] {
        OP_CLEAR_ENTRY = 3'd0,
        OP_STORE_FIRST = 3'd1,
        OP_GATHER      = 3'd2,
        OP_CLEAR_OUT   = 3'd3,
        OP_SCATTER     = 3'd4,
        OP_COMMIT_OUT  = 3'd5,
        OP_GROUND_FLUX = 3'd6,
        OP_SOURCE      = 3'd7
    } t_op;

    localparam logic KIND_GATHER = 1'b0;
    localparam logic KIND_SOURCE = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic       clr_en;
        logic       load;
        logic       rd_en;
        logic       mul_en;
        logic       mul_first;
        logic [1:0] mul_step;
        logic       wr_en;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic result_pending;
        logic out_full;
    } t_sts;

endpackage

// ----- design/sors_if.sv -----
// Channel interfaces: input items, result items and the threshold write.
// Depends on sors_pkg for field widths.
interface sors_in_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    operation;
    logic [sors_pkg::IDX_W-1:0]    first_index;
    logic [sors_pkg::IDX_W-1:0]    second_index;
    logic [sors_pkg::VAL_W-1:0]    coefficient;
    logic                          group_first;
    logic                          group_last;
    logic                          use_outgoing_total;
    modport source (output valid, operation, first_index, second_index, coefficient,
                    group_first, group_last, use_outgoing_total, input ready);
    modport sink (input valid, operation, first_index, second_index, coefficient,
                  group_first, group_last, use_outgoing_total, output ready);
endinterface

interface sors_out_if;
    logic                       valid;
    logic                       ready;
    logic [sors_pkg::VAL_W-1:0] result_value;
    logic                       result_kind;
    logic                       was_skipped;
    modport source (output valid, result_value, result_kind, was_skipped, input ready);
    modport sink (input valid, result_value, result_kind, was_skipped, output ready);
endinterface

interface sors_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [sors_pkg::THR_W-1:0] skip_threshold;
    modport source (output valid, skip_threshold, input ready);
    modport sink (input valid, skip_threshold, output ready);
endinterface

// ----- design/sors_ctrl.sv -----
// Sequencer for the radiance store: clearing pass, read, multiply, write.
// Depends on sors_pkg for the state, command and status types.
module sors_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  sors_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output sors_pkg::t_cmd o_cmd
);

    sors_pkg::t_state r_state, n_state;
    logic [1:0]       r_step, n_step;
    logic             w_hold;

    assign w_hold = i_sts.result_pending && i_sts.out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sors_pkg::S_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sors_pkg::S_CLEAR: if (i_sts.clr_done) n_state = sors_pkg::S_IDLE;
            sors_pkg::S_IDLE:  if (i_in_valid) n_state = sors_pkg::S_READ;
            sors_pkg::S_READ:  n_state = sors_pkg::S_MUL;
            sors_pkg::S_MUL: begin
                if (r_step == 2'(sors_pkg::MUL_STEPS - 1)) n_state = sors_pkg::S_WRITE;
            end
            sors_pkg::S_WRITE: if (!w_hold) n_state = sors_pkg::S_IDLE;
            default:           n_state = sors_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        n_step           = (r_state == sors_pkg::S_MUL) ? r_step + 2'd1 : 2'd0;
        o_in_ready       = (r_state == sors_pkg::S_IDLE);
        o_cmd.clr_en     = (r_state == sors_pkg::S_CLEAR);
        o_cmd.load       = (r_state == sors_pkg::S_IDLE) && i_in_valid;
        o_cmd.rd_en      = (r_state == sors_pkg::S_READ);
        o_cmd.mul_en     = (r_state == sors_pkg::S_MUL);
        o_cmd.mul_first  = (r_step == 2'd0);
        o_cmd.mul_step   = r_step;
        o_cmd.wr_en      = (r_state == sors_pkg::S_WRITE) && !w_hold;
    end

endmodule

// ----- design/sors_dp.sv -----
// Datapath: four radiance memories, iterative Q24.40 multiplier, group sums,
// threshold register and result register. Depends on sors_pkg, sors_out_if.
module sors_dp #(
    parameter int STORE_DEPTH   = 16384,
    parameter int FRACTION_BITS = 40
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sors_pkg::t_cmd               i_cmd,
    output sors_pkg::t_sts               o_sts,
    input  logic [2:0]                   i_operation,
    input  logic [sors_pkg::IDX_W-1:0]   i_first_index,
    input  logic [sors_pkg::IDX_W-1:0]   i_second_index,
    input  logic [sors_pkg::VAL_W-1:0]   i_coefficient,
    input  logic                         i_group_first,
    input  logic                         i_group_last,
    input  logic                         i_use_outgoing_total,
    input  logic                         i_cfg_we,
    input  logic [sors_pkg::THR_W-1:0]   i_cfg_threshold,
    sors_out_if.source                   o_out
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int IW = sors_pkg::IDX_W;
    localparam int VW = sors_pkg::VAL_W;
    localparam logic [VW-1:0] SAT_MAX = '1;

    // Item registers
    sors_pkg::t_op  r_op;
    logic [IW-1:0]  r_fi, r_si;
    logic [VW-1:0]  r_coef;
    logic           r_first, r_last, r_use_out;
    logic [sors_pkg::THR_W-1:0] r_thr;

    // Memories
    logic [VW-1:0] r_mem_in  [STORE_DEPTH];
    logic [VW-1:0] r_mem_it  [STORE_DEPTH];
    logic [VW-1:0] r_mem_out [STORE_DEPTH];
    logic [VW-1:0] r_mem_ot  [STORE_DEPTH];
    logic [VW-1:0] r_in_q, r_it_q, r_out_q, r_ot_q;
    logic [AW-1:0] r_clr_addr;

    // Multiplier and sums
    logic [2*VW-1:0] r_acc;
    logic [VW-1:0]   r_gsum, r_ssum;
    logic            r_gskip;

    // Result register
    logic          r_o_valid;
    logic [VW-1:0] r_res_value;
    logic          r_res_kind, r_res_skip;

    function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VW] ? SAT_MAX : s[VW-1:0];
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] idx);
        logic [AW+IW-1:0] t;
        t = {{AW{1'b0}}, idx};
        return t[AW-1:0];
    endfunction

    logic          w_fi_ok, w_si_ok, w_in_ok;
    logic [AW-1:0] w_fa, w_sa, w_in_ra, w_out_ra;
    logic [VW-1:0] w_in_v, w_it_v, w_out_v, w_ot_v, w_b, w_prod;
    logic [31:0]   w_a_part, w_b_part;
    logic [63:0]   w_pp;
    logic [2*VW-1:0] w_pp_sh;
    logic          w_below_in;
    logic [VW-1:0] w_gsum_n, w_ssum_n;
    logic          w_gskip_n;
    logic          w_we_in, w_we_it, w_we_out, w_we_ot;
    logic [VW-1:0] w_d_in, w_d_it, w_d_out, w_d_ot;
    logic [AW-1:0] w_wa;
    logic          w_result;

    assign w_fi_ok  = {18'b0, r_fi} < 32'(STORE_DEPTH);
    assign w_si_ok  = {18'b0, r_si} < 32'(STORE_DEPTH);
    assign w_fa     = to_addr(r_fi);
    assign w_sa     = to_addr(r_si);
    assign w_in_ra  = (r_op == sors_pkg::OP_GATHER) ? w_fa : w_sa;
    assign w_out_ra = (r_op == sors_pkg::OP_GATHER) ? w_sa : w_fa;
    assign w_in_ok  = (r_op == sors_pkg::OP_GATHER) ? w_fi_ok : w_si_ok;

    // Mask reads of entries beyond the store to zero
    assign w_in_v  = w_in_ok ? r_in_q : '0;
    assign w_it_v  = w_fi_ok ? r_it_q : '0;
    assign w_out_v = ((r_op == sors_pkg::OP_GATHER) ? w_si_ok : w_fi_ok) ? r_out_q : '0;
    assign w_ot_v  = w_fi_ok ? r_ot_q : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= sors_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_threshold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= sors_pkg::t_op'(i_operation);
            r_fi      <= i_first_index;
            r_si      <= i_second_index;
            r_coef    <= i_coefficient;
            r_first   <= i_group_first;
            r_last    <= i_group_last;
            r_use_out <= i_use_outgoing_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Multiplier operand: one 32x32 partial product per step
    always_comb begin
        unique case (r_op)
            sors_pkg::OP_GATHER: w_b = w_out_v;
            sors_pkg::OP_SOURCE: w_b = r_use_out ? w_ot_v : w_it_v;
            default:             w_b = w_in_v;
        endcase
    end

    assign w_a_part = i_cmd.mul_step[0] ? r_coef[63:32] : r_coef[31:0];
    assign w_b_part = i_cmd.mul_step[1] ? w_b[63:32] : w_b[31:0];
    assign w_pp     = w_a_part * w_b_part;

    always_comb begin
        unique case (i_cmd.mul_step)
            2'd0:    w_pp_sh = {64'b0, w_pp};
            2'd3:    w_pp_sh = {w_pp, 64'b0};
            default: w_pp_sh = {32'b0, w_pp, 32'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_acc <= (i_cmd.mul_first ? '0 : r_acc) + w_pp_sh;
        end
    end

    // Drop fraction bits, saturate on overflow
    assign w_prod = (|r_acc[2*VW-1:VW+FRACTION_BITS]) ? SAT_MAX
                                                      : r_acc[VW+FRACTION_BITS-1:FRACTION_BITS];
    assign w_below_in = w_in_v < {{(VW-sors_pkg::THR_W){1'b0}}, r_thr};

    assign w_gsum_n  = r_first ? w_prod : sat_add(r_gsum, w_prod);
    assign w_gskip_n = r_first ? w_below_in : r_gskip;
    assign w_ssum_n  = r_first ? w_prod : sat_add(r_ssum, w_prod);
    assign w_result  = r_last && (r_op == sors_pkg::OP_GATHER || r_op == sors_pkg::OP_SOURCE);

    always_comb begin
        w_we_in  = 1'b0;
        w_we_it  = 1'b0;
        w_we_out = 1'b0;
        w_we_ot  = 1'b0;
        w_d_in   = '0;
        w_d_it   = '0;
        w_d_out  = '0;
        w_d_ot   = '0;
        w_wa     = w_fa;
        if (i_cmd.clr_en) begin
            w_we_in  = 1'b1;
            w_we_it  = 1'b1;
            w_we_out = 1'b1;
            w_we_ot  = 1'b1;
            w_wa     = r_clr_addr;
        end else if (i_cmd.wr_en && w_fi_ok) begin
            unique case (r_op)
                sors_pkg::OP_CLEAR_ENTRY: begin
                    w_we_in  = 1'b1;
                    w_we_it  = 1'b1;
                    w_we_out = 1'b1;
                    w_we_ot  = 1'b1;
                end
                sors_pkg::OP_STORE_FIRST: begin
                    w_we_in = 1'b1;
                    w_we_it = 1'b1;
                    w_d_in  = r_coef;
                    w_d_it  = r_coef;
                end
                sors_pkg::OP_GATHER: begin
                    if (r_last) begin
                        w_we_in = 1'b1;
                        if (!w_gskip_n) begin
                            w_d_in  = w_gsum_n;
                            w_we_it = 1'b1;
                            w_d_it  = sat_add(w_it_v, w_gsum_n);
                        end
                    end
                end
                sors_pkg::OP_CLEAR_OUT: w_we_out = 1'b1;
                sors_pkg::OP_SCATTER: begin
                    w_we_out = !w_below_in;
                    w_d_out  = sat_add(w_out_v, w_prod);
                end
                sors_pkg::OP_COMMIT_OUT: begin
                    w_we_ot = 1'b1;
                    w_d_ot  = sat_add(w_ot_v, w_out_v);
                end
                sors_pkg::OP_GROUND_FLUX: begin
                    w_we_out = 1'b1;
                    w_d_out  = w_prod;
                    w_we_ot  = 1'b1;
                    w_d_ot   = sat_add(w_ot_v, w_prod);
                end
                sors_pkg::OP_SOURCE: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_in) r_mem_in[w_wa] <= w_d_in;
        if (i_cmd.rd_en) r_in_q <= r_mem_in[w_in_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_it) r_mem_it[w_wa] <= w_d_it;
        if (i_cmd.rd_en) r_it_q <= r_mem_it[w_fa];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_out) r_mem_out[w_wa] <= w_d_out;
        if (i_cmd.rd_en) r_out_q <= r_mem_out[w_out_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_ot) r_mem_ot[w_wa] <= w_d_ot;
        if (i_cmd.rd_en) r_ot_q <= r_mem_ot[w_fa];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gsum  <= '0;
            r_gskip <= 1'b0;
            r_ssum  <= '0;
        end else if (i_cmd.wr_en) begin
            if (r_op == sors_pkg::OP_GATHER) begin
                r_gsum  <= w_gsum_n;
                r_gskip <= w_gskip_n;
            end
            if (r_op == sors_pkg::OP_SOURCE) r_ssum <= w_ssum_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.wr_en && w_result) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && w_result) begin
            if (r_op == sors_pkg::OP_SOURCE) begin
                r_res_value <= w_ssum_n;
                r_res_kind  <= sors_pkg::KIND_SOURCE;
                r_res_skip  <= 1'b0;
            end else begin
                r_res_value <= w_gskip_n ? '0 : w_gsum_n;
                r_res_kind  <= sors_pkg::KIND_GATHER;
                r_res_skip  <= w_gskip_n;
            end
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.result_value = r_res_value;
    assign o_out.result_kind  = r_res_kind;
    assign o_out.was_skipped  = r_res_skip;

    assign o_sts.clr_done       = (r_clr_addr == AW'(STORE_DEPTH - 1));
    assign o_sts.result_pending = w_result;
    assign o_sts.out_full       = r_o_valid && !o_out.ready;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && w_result) |-> !(r_o_valid && !o_out.ready))
        else $error("result written over a stalled result");

    a_load_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> i_cmd.rd_en)
        else $error("memory read did not follow item load");

    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_en |-> !(i_cmd.wr_en || i_cmd.load))
        else $error("item activity during clearing pass");

    a_skip_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_res_skip) |-> (r_res_value == '0 && r_res_kind == sors_pkg::KIND_GATHER))
        else $error("skipped gather with nonzero value");

endmodule

// ----- design/scatter_order_radiance_store.sv -----
// Top level of the scatter-order radiance store.
// Depends on sors_pkg, the channel interfaces, sors_ctrl and sors_dp.
//
// Channels: i_in carries one term (operation, indices, Q24.40 coefficient,
// group flags); o_out carries finished gathers and source sums; i_cfg writes
// the 20-bit skip threshold and is always ready (write it only while idle).
// A transfer happens on a rising edge with valid and ready both high.
//
// Each term passes through accept, one registered memory read, four steps
// of the shared 32x32 multiplier (the full 64x64 product is built from
// partial products), then one read-modify-write into the stores.
// A result is loaded into the output register at the end of the write
// cycle and shows on o_out in the same cycle that the block is ready again.
//
// Reset: a clearing pass zeroes all four stores, one entry per cycle;
// i_in.ready stays low during it. The threshold resets to 110 (about 1e-10
// in Q24.40) and the group sums to zero.
//
// Stall: a waiting result holds in the output register while the next term
// is accepted; a term that finishes a group holds in its write cycle until
// the previous result has been taken.
module scatter_order_radiance_store #(
    parameter int STORE_DEPTH   = 16384,
    parameter int FRACTION_BITS = 40
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sors_in_if.sink    i_in,
    sors_out_if.source o_out,
    sors_cfg_if.sink   i_cfg
);

    sors_pkg::t_cmd w_cmd;
    sors_pkg::t_sts w_sts;
    logic           w_in_ready;

    // Threshold register never stalls
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;

    sors_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    sors_dp #(
        .STORE_DEPTH   (STORE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .i_operation          (i_in.operation),
        .i_first_index        (i_in.first_index),
        .i_second_index       (i_in.second_index),
        .i_coefficient        (i_in.coefficient),
        .i_group_first        (i_in.group_first),
        .i_group_last         (i_in.group_last),
        .i_use_outgoing_total (i_in.use_outgoing_total),
        .i_cfg_we             (i_cfg.valid),
        .i_cfg_threshold      (i_cfg.skip_threshold),
        .o_out                (o_out)
    );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the scatter-order radiance store.
// Drives terms and threshold writes, predicts results from a local model of the stores.
// Depends on sors_pkg, the channel interfaces and scatter_order_radiance_store.
module tb_top;

    localparam int DEPTH = 16384;
    localparam int FRAC = 40;
    localparam logic [63:0] QMAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int STALL_LIMIT = 4 * DEPTH;

    typedef struct packed {
        logic [63:0] value;
        logic        kind;
        logic        skipped;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sors_in_if  in_ch();
    sors_out_if out_ch();
    sors_cfg_if cfg_ch();

    scatter_order_radiance_store uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // Local copy of the block state
    logic [63:0] inc_mem [DEPTH];
    logic [63:0] inc_tot_mem [DEPTH];
    logic [63:0] out_mem [DEPTH];
    logic [63:0] out_tot_mem [DEPTH];
    logic [63:0] gather_acc;
    logic        gather_zero;
    logic [63:0] source_acc;
    logic [sors_pkg::THR_W-1:0] threshold;

    t_result pending_results[$];
    int errors = 0;
    int results_seen = 0;
    int terms_sent = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int take_stall_pct = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] qsum(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? QMAX : s[63:0];
    endfunction

    function automatic logic [63:0] qprod(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return (p[127:FRAC+64] != 0) ? QMAX : p[FRAC+63:FRAC];
    endfunction

    // Apply one term to the local stores; queue the result it produces
    task automatic predict_term(input sors_pkg::t_op op, input int fi, input int si,
                                input logic [63:0] c,
                                input logic gf, input logic gl, input logic uo);
        logic [63:0] v;
        begin
            case (op)
                sors_pkg::OP_CLEAR_ENTRY: begin
                    inc_mem[fi] = 0; inc_tot_mem[fi] = 0; out_mem[fi] = 0; out_tot_mem[fi] = 0;
                end
                sors_pkg::OP_STORE_FIRST: begin
                    inc_mem[fi] = c; inc_tot_mem[fi] = c;
                end
                sors_pkg::OP_GATHER: begin
                    v = qprod(c, out_mem[si]);
                    if (gf) begin
                        gather_acc = v;
                        gather_zero = inc_mem[fi] < {44'd0, threshold};
                    end else begin
                        gather_acc = qsum(gather_acc, v);
                    end
                    if (gl) begin
                        if (gather_zero) begin
                            inc_mem[fi] = 0;
                            pending_results.push_back('{64'd0, sors_pkg::KIND_GATHER, 1'b1});
                        end else begin
                            inc_mem[fi] = gather_acc;
                            inc_tot_mem[fi] = qsum(inc_tot_mem[fi], gather_acc);
                            pending_results.push_back('{gather_acc, sors_pkg::KIND_GATHER,
                                                        1'b0});
                        end
                    end
                end
                sors_pkg::OP_CLEAR_OUT: out_mem[fi] = 0;
                sors_pkg::OP_SCATTER: begin
                    v = inc_mem[si];
                    if (v >= {44'd0, threshold})
                        out_mem[fi] = qsum(out_mem[fi], qprod(c, v));
                end
                sors_pkg::OP_COMMIT_OUT: out_tot_mem[fi] = qsum(out_tot_mem[fi], out_mem[fi]);
                sors_pkg::OP_GROUND_FLUX: begin
                    v = qprod(c, inc_mem[si]);
                    out_mem[fi] = v;
                    out_tot_mem[fi] = qsum(out_tot_mem[fi], v);
                end
                default: begin
                    v = qprod(c, uo ? out_tot_mem[fi] : inc_tot_mem[fi]);
                    source_acc = gf ? v : qsum(source_acc, v);
                    if (gl)
                        pending_results.push_back('{source_acc, sors_pkg::KIND_SOURCE, 1'b0});
                end
            endcase
        end
    endtask

    // Send one term: random idle before it, hold valid until the transfer
    task automatic send_term(input sors_pkg::t_op op, input int fi, input int si,
                             input logic [63:0] c,
                             input logic gf, input logic gl, input logic uo);
        begin
            while ($urandom_range(99) < send_idle_pct) begin
                in_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.operation <= op;
            in_ch.first_index <= fi[sors_pkg::IDX_W-1:0];
            in_ch.second_index <= si[sors_pkg::IDX_W-1:0];
            in_ch.coefficient <= c;
            in_ch.group_first <= gf;
            in_ch.group_last <= gl;
            in_ch.use_outgoing_total <= uo;
            @(posedge i_clk);
            while (!in_ch.ready)
                @(posedge i_clk);
            predict_term(op, fi, si, c, gf, gl, uo);
            terms_sent++;
            @(negedge i_clk);
        end
    endtask

    // Drop valid, wait for every expected result, then let the last term drain
    task automatic drain;
        begin
            in_ch.valid <= 1'b0;
            while (pending_results.size() != 0)
                @(negedge i_clk);
            repeat (12) @(negedge i_clk);
        end
    endtask

    task automatic write_threshold(input logic [sors_pkg::THR_W-1:0] thr);
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.skip_threshold <= thr;
            @(posedge i_clk);
            while (!cfg_ch.ready)
                @(posedge i_clk);
            threshold = thr;
            @(negedge i_clk);
            cfg_ch.valid <= 1'b0;
        end
    endtask

    // Compare each transfer on the result channel with the oldest expectation
    always @(posedge i_clk) begin
        t_result got, want;
        if (out_ch.valid && out_ch.ready) begin
            got = '{out_ch.result_value, out_ch.result_kind, out_ch.was_skipped};
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value=%h kind=%0b skipped=%0b",
                         $time, got.value, got.kind, got.skipped);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value) begin
                    $display("%0t: value expected %h actual %h", $time, want.value, got.value);
                    errors++;
                end
                if (got.kind !== want.kind) begin
                    $display("%0t: kind expected %0b actual %0b", $time, want.kind, got.kind);
                    errors++;
                end
                if (got.skipped !== want.skipped) begin
                    $display("%0t: skip flag expected %0b actual %0b",
                             $time, want.skipped, got.skipped);
                    errors++;
                end
            end
        end
    end

    // Randomly stall the result channel
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= take_stall_pct);
    end

    // Watchdog: count cycles with no transfer anywhere; reset clearing pass included
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_ch.valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Coefficient mix: corners, small Q values, full random
    function automatic logic [63:0] rand_coef();
        case ($urandom_range(5))
            0: return QMAX;
            1: return 64'd0;
            2: return 64'd1 << FRAC;
            3: return {44'd0, 20'($urandom)};
            4: return {24'($urandom_range(7)), 40'({$urandom, $urandom})};
            default: return rand64();
        endcase
    endfunction

    function automatic int rand_idx();
        return ($urandom_range(9) == 0) ? $urandom_range(DEPTH - 1) : $urandom_range(15);
    endfunction

    task automatic test_directed;
        begin
            send_term(sors_pkg::OP_STORE_FIRST, 0, 0, 64'd3 << FRAC, 0, 0, 0);
            send_term(sors_pkg::OP_STORE_FIRST, DEPTH - 1, 0, QMAX, 0, 0, 0);
            send_term(sors_pkg::OP_STORE_FIRST, 1, 0, 64'd109, 0, 0, 0);
            send_term(sors_pkg::OP_STORE_FIRST, 2, 0, 64'd110, 0, 0, 0);
            send_term(sors_pkg::OP_SCATTER, 3, 0, 64'd1 << FRAC, 0, 0, 0);
            send_term(sors_pkg::OP_SCATTER, 3, 1, QMAX, 0, 0, 0);          // source below threshold
            send_term(sors_pkg::OP_SCATTER, 4, 2, 64'd1 << FRAC, 0, 0, 0); // exactly at threshold
            send_term(sors_pkg::OP_SCATTER, 5, DEPTH - 1, QMAX, 0, 0, 0);  // product saturates
            send_term(sors_pkg::OP_SCATTER, 5, DEPTH - 1, QMAX, 0, 0, 0);  // sum saturates
            send_term(sors_pkg::OP_GROUND_FLUX, 6, 0, 64'd2 << FRAC, 1, 1, 1);
            send_term(sors_pkg::OP_COMMIT_OUT, 5, 0, 0, 0, 0, 0);
            send_term(sors_pkg::OP_COMMIT_OUT, 3, 0, 0, 0, 0, 0);
            send_term(sors_pkg::OP_GATHER, 0, 3, 64'd1 << FRAC, 1, 0, 0);
            send_term(sors_pkg::OP_GATHER, 0, 5, QMAX, 0, 1, 0);           // saturating gather
            send_term(sors_pkg::OP_GATHER, 1, 3, 64'd1 << FRAC, 1, 1, 0);  // destination skipped
            send_term(sors_pkg::OP_GATHER, 2, 6, 64'd5, 1, 1, 0);
            send_term(sors_pkg::OP_SOURCE, 0, 0, 64'd1 << FRAC, 1, 0, 0);
            send_term(sors_pkg::OP_SOURCE, 5, 0, 64'd1 << FRAC, 0, 1, 1);
            send_term(sors_pkg::OP_SOURCE, DEPTH - 1, 0, QMAX, 1, 1, 0);
            send_term(sors_pkg::OP_CLEAR_OUT, 5, 0, QMAX, 1, 1, 1);        // group flags ignored
            send_term(sors_pkg::OP_CLEAR_ENTRY, DEPTH - 1, DEPTH - 1, QMAX, 1, 1, 1);
            send_term(sors_pkg::OP_SOURCE, DEPTH - 1, 0, QMAX, 1, 1, 1);
            send_term(sors_pkg::OP_SOURCE, 0, 0, 64'd7, 0, 1, 0);          // term outside a group
            drain();
        end
    endtask

    // Random traffic, mostly well-formed groups with noise in between
    task automatic test_random(input int n_items);
        int sent, len, dest, k;
        sors_pkg::t_op op;
        begin
            sent = 0;
            while (sent < n_items) begin
                k = $urandom_range(9);
                if (k < 3 || k == 9) begin
                    op = (k < 2) ? sors_pkg::OP_GATHER : sors_pkg::OP_SOURCE;
                    len = $urandom_range(1, 4);
                    dest = rand_idx();
                    for (int j = 0; j < len; j++) begin
                        send_term(op, (k == 9) ? rand_idx() : dest, rand_idx(), rand_coef(),
                                  (j == 0) ^ ($urandom_range(19) == 0),
                                  (j == len - 1) ^ ($urandom_range(19) == 0),
                                  $urandom_range(1));
                        sent++;
                    end
                end else begin
                    op = sors_pkg::t_op'((k == 3) ? sors_pkg::OP_STORE_FIRST
                                                  : $urandom_range(7));
                    send_term(op, rand_idx(), rand_idx(), rand_coef(),
                              $urandom_range(1), $urandom_range(1), $urandom_range(1));
                    sent++;
                end
            end
            drain();
        end
    endtask

    task automatic test_thresholds;
        begin
            write_threshold('0);
            test_random(40);
            write_threshold('1);
            test_random(40);
            write_threshold(20'($urandom));
            test_random(30);
            write_threshold(sors_pkg::THR_RESET);
        end
    endtask

    task automatic test_idling;
        begin
            send_idle_pct = 79; take_stall_pct = 0;
            test_random(100);
            send_idle_pct = 0; take_stall_pct = 79;
            test_random(100);
            send_idle_pct = 10; take_stall_pct = 10;
            test_random(100);
            send_idle_pct = 0; take_stall_pct = 0;
            test_random(120);
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.operation = sors_pkg::OP_CLEAR_ENTRY;
        in_ch.first_index = '0;
        in_ch.second_index = '0;
        in_ch.coefficient = '0;
        in_ch.group_first = 1'b0;
        in_ch.group_last = 1'b0;
        in_ch.use_outgoing_total = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.skip_threshold = '0;
        for (int j = 0; j < DEPTH; j++) begin
            inc_mem[j] = 0; inc_tot_mem[j] = 0; out_mem[j] = 0; out_tot_mem[j] = 0;
        end
        gather_acc = 0;
        gather_zero = 0;
        source_acc = 0;
        threshold = sors_pkg::THR_RESET;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_thresholds();
        test_idling();

        $display("Sent %0d terms over four threshold settings and four idling mixes,", terms_sent);
        $display("checked %0d gather and source results.", results_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- scatter_order_radiance_store.f -----
design/sors_pkg.sv
design/sors_if.sv
design/sors_ctrl.sv
design/sors_dp.sv
design/scatter_order_radiance_store.sv
dv/tb_top.sv
